// ===== hdl/pls_pkg.sv =====
// pls_pkg: request codes, status codes and the result record of the list store
// no dependencies

package pls_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 7;
  localparam int unsigned CountW = 7;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned StatW  = 2;

  localparam logic [TypeW-1:0] REQ_INS_HEAD = 3'd0;
  localparam logic [TypeW-1:0] REQ_INS_TAIL = 3'd1;
  localparam logic [TypeW-1:0] REQ_INS_POS  = 3'd2;
  localparam logic [TypeW-1:0] REQ_DEL_HEAD = 3'd3;
  localparam logic [TypeW-1:0] REQ_DEL_TAIL = 3'd4;
  localparam logic [TypeW-1:0] REQ_DEL_POS  = 3'd5;

  localparam logic [StatW-1:0] ST_OK     = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd1;
  localparam logic [StatW-1:0] ST_BADPOS = 2'd2;
  localparam logic [StatW-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [StatW-1:0]        status;
    logic signed [DataW-1:0] removed;
    logic [CountW-1:0]       count;
  } res_t;

endpackage

// ===== hdl/positional_list_store.sv =====
// positional_list_store: ordered list of signed values held packed in one entry memory
// sequencing: failed or unused requests go straight to the result state; an insert at
//   index k moves the entries from the tail down to k up one place, then writes the value;
//   a delete at index k reads the removed entry, then moves each entry above it down one;
//   one request at a time, set by the entry-by-entry shift (one read and one write per cycle)
// reset: the count and handshake clear at once; the entry memory is not cleared

module positional_list_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pls_pkg::TypeW-1:0]          req_type_i,
  input  logic signed [pls_pkg::DataW-1:0]   item_value_i,
  input  logic [pls_pkg::PosW-1:0]           position_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pls_pkg::StatW-1:0]          status_o,
  output logic signed [pls_pkg::DataW-1:0]   removed_value_o,
  output logic [pls_pkg::CountW-1:0]         entry_count_o
);
  import pls_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [DataW-1:0] wr_data, rd_data;
  logic             res_valid, res_ready;
  res_t             res;

  logic             out_valid_q;
  res_t             out_q;

  pls_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .position_i   (position_i),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  pls_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // output register takes a result whenever its slot is free or being emptied
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign removed_value_o = out_q.removed;
  assign entry_count_o   = out_q.count;

endmodule

// ===== hdl/pls_ram.sv =====
// pls_ram: entry memory, one write port and one registered read port
// depends on pls_pkg for the data width

module pls_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [pls_pkg::DataW-1:0]  wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [pls_pkg::DataW-1:0]  rd_data_o
);
  import pls_pkg::*;

  logic [DataW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== hdl/pls_ctrl.sv =====
// pls_ctrl: request decode and the shift sequencer that moves entries through the memory
// depends on pls_pkg; drives the ports of pls_ram

module pls_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pls_pkg::TypeW-1:0]   req_type_i,
  input  logic signed [pls_pkg::DataW-1:0] item_value_i,
  input  logic [pls_pkg::PosW-1:0]    position_i,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [pls_pkg::DataW-1:0]   wr_data_o,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  input  logic [pls_pkg::DataW-1:0]   rd_data_i,
  output logic                        res_valid_o,
  output pls_pkg::res_t               res_o,
  input  logic                        res_ready_i
);
  import pls_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_INS_SHIFT = 6'b000010,
    S_INS_PUT   = 6'b000100,
    S_DEL_GET   = 6'b001000,
    S_DEL_SHIFT = 6'b010000,
    S_DONE      = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           cur_q, cur_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [DataW-1:0]        val_q, val_d;
  logic [StatW-1:0]        status_q, status_d;
  logic [DataW-1:0]        removed_q, removed_d;

  logic                    in_acc;
  logic                    is_full, is_empty;
  logic [PosW:0]           pos_x, cnt_x;
  logic [StatW-1:0]        dec_status;
  logic                    dec_ins, dec_del;
  logic [AW-1:0]           dec_idx;
  logic [AW-1:0]           last_idx;
  logic [AW-1:0]           pos_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign pos_x    = {1'b0, position_i};
  assign cnt_x    = (PosW+1)'(count_q);
  assign last_idx = AW'(count_q - CW'(1));
  assign pos_idx  = AW'(position_i - PosW'(1));

  // decode the request against the current fill
  always_comb begin
    dec_status = ST_OK;
    dec_ins    = 1'b0;
    dec_del    = 1'b0;
    dec_idx    = '0;
    case (req_type_i)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (is_full) begin
          dec_status = ST_FULL;
        end else if (req_type_i == REQ_INS_POS &&
                     (position_i == '0 || pos_x > cnt_x + (PosW+1)'(1))) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_ins = 1'b1;
          if (req_type_i == REQ_INS_HEAD) begin
            dec_idx = '0;
          end else if (req_type_i == REQ_INS_TAIL) begin
            dec_idx = AW'(count_q);
          end else begin
            dec_idx = pos_idx;
          end
        end
      end
      REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
        if (is_empty) begin
          dec_status = ST_EMPTY;
        end else if (req_type_i == REQ_DEL_POS &&
                     (position_i == '0 || pos_x > cnt_x)) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_del = 1'b1;
          if (req_type_i == REQ_DEL_HEAD) begin
            dec_idx = '0;
          end else if (req_type_i == REQ_DEL_TAIL) begin
            dec_idx = last_idx;
          end else begin
            dec_idx = pos_idx;
          end
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    val_d     = val_q;
    status_d  = status_q;
    removed_d = removed_q;
    wr_en_o   = 1'b0;
    wr_addr_o = cur_q;
    wr_data_o = rd_data_i;
    rd_en_o   = 1'b0;
    rd_addr_o = cur_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          status_d  = dec_status;
          removed_d = '0;
          val_d     = item_value_i;
          idx_d     = dec_idx;
          if (dec_ins) begin
            if (dec_idx == AW'(count_q)) begin
              state_d = S_INS_PUT;
            end else begin
              // walk down from the tail, each entry moves up one place
              rd_en_o   = 1'b1;
              rd_addr_o = last_idx;
              cur_d     = last_idx;
              state_d   = S_INS_SHIFT;
            end
          end else if (dec_del) begin
            rd_en_o   = 1'b1;
            rd_addr_o = dec_idx;
            cur_d     = dec_idx;
            state_d   = S_DEL_GET;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_INS_SHIFT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = cur_q + AW'(1);
        if (cur_q == idx_q) begin
          state_d = S_INS_PUT;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = cur_q - AW'(1);
          cur_d     = cur_q - AW'(1);
        end
      end
      S_INS_PUT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q;
        wr_data_o = val_q;
        count_d   = count_q + CW'(1);
        state_d   = S_DONE;
      end
      S_DEL_GET: begin
        removed_d = rd_data_i;
        if (cur_q == last_idx) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = cur_q + AW'(1);
          cur_d     = cur_q + AW'(1);
          state_d   = S_DEL_SHIFT;
        end
      end
      S_DEL_SHIFT: begin
        // close the gap: entry moves down one place
        wr_en_o   = 1'b1;
        wr_addr_o = cur_q - AW'(1);
        if (cur_q == last_idx) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = cur_q + AW'(1);
          cur_d     = cur_q + AW'(1);
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_valid_o    = (state_q == S_DONE);
  assign res_o.status   = status_q;
  assign res_o.removed  = removed_q;
  assign res_o.count    = CountW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

endmodule
